FILE: rtl/core/skcs_pkg.sv
// ----------------------------------------------------------------------------
// skcs_pkg
// Shared types and constants for the keyed callback stack block: field
// widths, result kinds, operation codes and the structs between modules.
// ----------------------------------------------------------------------------
package skcs_pkg;

    // Field widths of the input and result beats.
    localparam int OP_W   = 2;
    localparam int TID_W  = 2;
    localparam int KEY_W  = 48;
    localparam int CB_W   = 16;
    localparam int DATA_W = 32;
    localparam int KIND_W = 3;

    // Number of thread ids that the thread field can name.
    localparam int NUM_TID = 1 << TID_W;

    // One stored entry: key, callback handle and data handle.
    localparam int ENTRY_W = KEY_W + CB_W + DATA_W;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [KIND_W-1:0] t_kind;

    // Operation codes; the fourth code is unused and only answers done.
    localparam t_op OP_REGISTER = 2'd0;
    localparam t_op OP_RETURN   = 2'd1;
    localparam t_op OP_UNWIND   = 2'd2;

    // Result kinds.
    localparam t_kind KIND_REGISTERED = 3'd0;
    localparam t_kind KIND_DUPLICATE  = 3'd1;
    localparam t_kind KIND_FULL       = 3'd2;
    localparam t_kind KIND_MISSED     = 3'd3;
    localparam t_kind KIND_RETURN     = 3'd4;
    localparam t_kind KIND_UNWIND     = 3'd5;
    localparam t_kind KIND_DONE       = 3'd6;

    // Outcome of the shared compare unit.
    typedef struct packed {
        logic key_lt;
        logic key_eq;
        logic cb_eq;
    } t_cmp;

    // One result beat as handed from the sequencer to the output register.
    typedef struct packed {
        t_kind             kind;
        logic [TID_W-1:0]  thread;
        logic [CB_W-1:0]   callback;
        logic [DATA_W-1:0] data;
        logic [KEY_W-1:0]  return_ref;
        logic              last;
    } t_result;

endpackage

FILE: rtl/core/skcs_ram.sv
// ----------------------------------------------------------------------------
// skcs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module skcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/skcs_cmp.sv
// ----------------------------------------------------------------------------
// skcs_cmp
// Shared compare unit: orders a stored key against the item's pointer and
// matches a stored callback handle against the item's handle.
// ----------------------------------------------------------------------------
module skcs_cmp import skcs_pkg::*; (
    input  logic [KEY_W-1:0] i_entry_key,
    input  logic [KEY_W-1:0] i_item_key,
    input  logic [CB_W-1:0]  i_entry_cb,
    input  logic [CB_W-1:0]  i_item_cb,
    output t_cmp             o_cmp
);

    // One magnitude compare and two equality compares.
    always_comb begin
        o_cmp.key_lt = i_entry_key < i_item_key;
        o_cmp.key_eq = i_entry_key == i_item_key;
        o_cmp.cb_eq  = i_entry_cb == i_item_cb;
    end

endmodule

FILE: rtl/core/skcs_ctrl.sv
// ----------------------------------------------------------------------------
// skcs_ctrl
// Sequencer of the keyed callback stack: holds the item, the fill counts
// and the entry memory, and walks the top of a stack one entry at a time
// through the shared compare unit.
// ----------------------------------------------------------------------------
module skcs_ctrl import skcs_pkg::*; #(
    parameter int STACK_DEPTH  = 32,
    parameter int THREAD_COUNT = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_op               i_op,
    input  logic [TID_W-1:0]  i_thread_id,
    input  logic [KEY_W-1:0]  i_stack_pointer,
    input  logic [CB_W-1:0]   i_callback_id,
    input  logic [DATA_W-1:0] i_user_data,
    input  logic [KEY_W-1:0]  i_return_ref,
    input  logic              i_out_free,
    output logic              o_push,
    output t_result           o_result
);

    localparam int USED_THREADS = (THREAD_COUNT < NUM_TID) ? THREAD_COUNT : NUM_TID;
    localparam int RAM_DEPTH    = USED_THREADS * STACK_DEPTH;
    localparam int ADDR_W       = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam int FILL_W       = $clog2(STACK_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DISP = 6'b000010,
        S_RD   = 6'b000100,
        S_EV   = 6'b001000,
        S_FIN  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    t_op               r_op;
    logic [TID_W-1:0]  r_tid;
    logic [KEY_W-1:0]  r_sp;
    logic [CB_W-1:0]   r_cb;
    logic [DATA_W-1:0] r_data;
    logic [KEY_W-1:0]  r_rref;
    logic [FILL_W-1:0] r_idx, n_idx;
    logic              r_miss, n_miss;
    logic [FILL_W-1:0] r_fill [NUM_TID];

    logic               fill_dec;
    logic               fill_inc;
    logic               thread_ok;
    logic               take;
    logic [ADDR_W-1:0]  base_addr;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [KEY_W-1:0]   ent_key;
    logic [CB_W-1:0]    ent_cb;
    logic [DATA_W-1:0]  ent_data;
    t_cmp               cmp;

    // Entry memory: one word per slot, thread-major.
    skcs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign {ent_key, ent_cb, ent_data} = ram_rdata;

    // The one compare unit that every scan and pop step goes through.
    skcs_cmp u_cmp (
        .i_entry_key (ent_key),
        .i_item_key  (r_sp),
        .i_entry_cb  (ent_cb),
        .i_item_cb   (r_cb),
        .o_cmp       (cmp)
    );

    assign thread_ok  = 32'(r_tid) < THREAD_COUNT;
    assign base_addr  = ADDR_W'(32'(r_tid) * STACK_DEPTH);
    assign o_in_ready = r_state == S_IDLE;

    // Pop condition: below the key while missed entries drain, then equal
    // for a return, or at or below for an unwind.
    always_comb begin
        if (r_miss) begin
            take = cmp.key_lt;
        end else if (r_op == OP_RETURN) begin
            take = cmp.key_eq;
        end else begin
            take = cmp.key_lt | cmp.key_eq;
        end
    end

    // Sequencer next state and result beat.
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_miss    = r_miss;
        fill_dec  = 1'b0;
        fill_inc  = 1'b0;
        o_push    = 1'b0;
        o_result  = '0;
        o_result.thread = r_tid;
        ram_we    = 1'b0;
        ram_waddr = base_addr + ADDR_W'(r_fill[r_tid]);
        ram_wdata = {r_sp, r_cb, r_data};
        ram_raddr = base_addr + ADDR_W'(r_idx - FILL_W'(1));
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_idx  = r_fill[r_tid];
                n_miss = r_op == OP_RETURN;
                if (thread_ok && (r_op == OP_REGISTER || r_op == OP_RETURN ||
                                  r_op == OP_UNWIND)) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RD: begin
                if (r_idx == '0) begin
                    n_state = (r_op == OP_REGISTER) ? S_FIN : S_DONE;
                end else begin
                    n_state = S_EV;
                end
            end
            S_EV: begin
                if (r_op == OP_REGISTER) begin
                    // Scan of the run of equal keys for the same callback.
                    if (!cmp.key_eq) begin
                        n_state = S_FIN;
                    end else if (cmp.cb_eq) begin
                        if (i_out_free) begin
                            o_push        = 1'b1;
                            o_result.kind = KIND_DUPLICATE;
                            n_state       = S_DONE;
                        end
                    end else begin
                        n_idx   = r_idx - FILL_W'(1);
                        n_state = S_RD;
                    end
                end else if (take) begin
                    // Pop and fire the top entry.
                    if (i_out_free) begin
                        o_push            = 1'b1;
                        o_result.callback = ent_cb;
                        o_result.data     = ent_data;
                        if (r_miss) begin
                            o_result.kind = KIND_MISSED;
                        end else if (r_op == OP_RETURN) begin
                            o_result.kind       = KIND_RETURN;
                            o_result.return_ref = r_rref;
                        end else begin
                            o_result.kind = KIND_UNWIND;
                        end
                        fill_dec = 1'b1;
                        n_idx    = r_idx - FILL_W'(1);
                        n_state  = S_RD;
                    end
                end else if (r_miss) begin
                    // Same top entry is tried again for the equal-key pass.
                    n_miss = 1'b0;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_push  = 1'b1;
                    n_state = S_DONE;
                    if (r_fill[r_tid] >= FILL_W'(STACK_DEPTH)) begin
                        o_result.kind = KIND_FULL;
                    end else begin
                        o_result.kind = KIND_REGISTERED;
                        ram_we        = 1'b1;
                        fill_inc      = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_push        = 1'b1;
                    o_result.kind = KIND_DONE;
                    o_result.last = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and fill counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_miss  <= 1'b0;
            r_idx   <= '0;
            for (int t = 0; t < NUM_TID; t++) begin
                r_fill[t] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_miss  <= n_miss;
            r_idx   <= n_idx;
            if (fill_dec) begin
                r_fill[r_tid] <= r_idx - FILL_W'(1);
            end else if (fill_inc) begin
                r_fill[r_tid] <= r_fill[r_tid] + FILL_W'(1);
            end
        end
    end

    // Item capture on an accepted input beat.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op   <= i_op;
            r_tid  <= i_thread_id;
            r_sp   <= i_stack_pointer;
            r_cb   <= i_callback_id;
            r_data <= i_user_data;
            r_rref <= i_return_ref;
        end
    end

endmodule

FILE: rtl/core/stack_keyed_callback_stack_top.sv
// Sequence: an item is captured and dispatched, then walks its stack with a memory read
// and a compare step per entry it visits; a register that is no duplicate adds the push
// or full beat, a return a switch of passes, and output stalls add theirs.
// Throughput: one item at a time; every entry step is a registered memory read
// followed by one pass through the shared compare unit, so rate tracks depth.
// Reset: synchronous, active low; empties every stack, entry memory is not cleared.
// ----------------------------------------------------------------------------
// stack_keyed_callback_stack_top
// Per-thread stacks of callbacks keyed by stack pointer: register, fire on
// return and fire on unwind, each item closed by a done beat marked last.
// ----------------------------------------------------------------------------
module stack_keyed_callback_stack_top import skcs_pkg::*; #(
    parameter int STACK_DEPTH  = 32,
    parameter int THREAD_COUNT = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [OP_W-1:0]   i_op,
    input  logic [TID_W-1:0]  i_thread_id,
    input  logic [KEY_W-1:0]  i_stack_pointer,
    input  logic [CB_W-1:0]   i_callback_id,
    input  logic [DATA_W-1:0] i_user_data,
    input  logic [KEY_W-1:0]  i_return_ref,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [KIND_W-1:0] o_result_kind,
    output logic [TID_W-1:0]  o_out_thread,
    output logic [CB_W-1:0]   o_fired_callback,
    output logic [DATA_W-1:0] o_fired_data,
    output logic [KEY_W-1:0]  o_fired_return_ref,
    output logic              o_last
);

    logic    r_out_valid;
    t_result r_res;
    logic    out_free;
    logic    push;
    t_result res;

    // The output slot can take a new beat when empty or being drained.
    assign out_free = !r_out_valid || i_out_ready;

    skcs_ctrl #(
        .STACK_DEPTH  (STACK_DEPTH),
        .THREAD_COUNT (THREAD_COUNT)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_thread_id     (i_thread_id),
        .i_stack_pointer (i_stack_pointer),
        .i_callback_id   (i_callback_id),
        .i_user_data     (i_user_data),
        .i_return_ref    (i_return_ref),
        .i_out_free      (out_free),
        .o_push          (push),
        .o_result        (res)
    );

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_res <= res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_result_kind      = r_res.kind;
    assign o_out_thread       = r_res.thread;
    assign o_fired_callback   = r_res.callback;
    assign o_fired_data       = r_res.data;
    assign o_fired_return_ref = r_res.return_ref;
    assign o_last             = r_res.last;

    // The sequencer is busy in the cycle after it takes an item.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted again right after an accept");

    // Only the done beat carries last.
    a_last_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_result_kind == KIND_DONE)
        else $error("last set on a beat that is not done");

    // Beats that pop nothing carry zero handles.
    a_nonfired_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == KIND_REGISTERED ||
                        o_result_kind == KIND_DUPLICATE ||
                        o_result_kind == KIND_FULL || o_result_kind == KIND_DONE)
        |-> o_fired_callback == '0 && o_fired_data == '0 && o_fired_return_ref == '0)
        else $error("non-fired beat carries handles");

    // Missed and unwound entries pass no return reference.
    a_no_rref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == KIND_MISSED || o_result_kind == KIND_UNWIND)
        |-> o_fired_return_ref == '0)
        else $error("return reference on a missed or unwound beat");

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the keyed callback stack block against a behavioral copy of the
// per-thread stacks. Every accepted item is run through that copy to build the
// list of result beats it must produce, and a monitor compares each result
// beat field by field, in order. Stimulus runs from hand-picked corner items
// through a stack filled to the top, to random call and return sequences
// under random idling, back-pressure and pauses.
// ----------------------------------------------------------------------------
module testbench import skcs_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH  = 32;
    localparam int THREAD_COUNT = 4;

    // The fourth operation code has no name in the package.
    localparam t_op OP_UNUSED = 2'd3;

    localparam logic [KEY_W-1:0] KEY_MAX     = '1;
    localparam int               CYCLE_LIMIT = 200000;
    localparam int               HOLD_CYCLES = 300;
    localparam int               TAIL_CYCLES = 80;
    localparam int               IDLE_PCT    = 37;

    // One input beat.
    typedef struct {
        t_op               op;
        logic [TID_W-1:0]  tid;
        logic [KEY_W-1:0]  sp;
        logic [CB_W-1:0]   cb;
        logic [DATA_W-1:0] data;
        logic [KEY_W-1:0]  rref;
    } t_call_event;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [OP_W-1:0]   i_op;
    logic [TID_W-1:0]  i_thread_id;
    logic [KEY_W-1:0]  i_stack_pointer;
    logic [CB_W-1:0]   i_callback_id;
    logic [DATA_W-1:0] i_user_data;
    logic [KEY_W-1:0]  i_return_ref;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [KIND_W-1:0] o_result_kind;
    logic [TID_W-1:0]  o_out_thread;
    logic [CB_W-1:0]   o_fired_callback;
    logic [DATA_W-1:0] o_fired_data;
    logic [KEY_W-1:0]  o_fired_return_ref;
    logic              o_last;

    // Shadow copy of the stacks and the result beats still owed.
    logic [KEY_W-1:0]  st_key  [THREAD_COUNT][STACK_DEPTH];
    logic [CB_W-1:0]   st_cb   [THREAD_COUNT][STACK_DEPTH];
    logic [DATA_W-1:0] st_data [THREAD_COUNT][STACK_DEPTH];
    int                st_fill [THREAD_COUNT];
    t_result           owed_results[$];

    int fail_count    = 0;
    int hold_requests = 0;
    bit steady        = 1'b0;

    stack_keyed_callback_stack_top #(
        .STACK_DEPTH  (STACK_DEPTH),
        .THREAD_COUNT (THREAD_COUNT)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_op               (i_op),
        .i_thread_id        (i_thread_id),
        .i_stack_pointer    (i_stack_pointer),
        .i_callback_id      (i_callback_id),
        .i_user_data        (i_user_data),
        .i_return_ref       (i_return_ref),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_result_kind      (o_result_kind),
        .o_out_thread       (o_out_thread),
        .o_fired_callback   (o_fired_callback),
        .o_fired_data       (o_fired_data),
        .o_fired_return_ref (o_fired_return_ref),
        .o_last             (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void owe_result(t_kind kind, int t, logic [CB_W-1:0] cb,
                                       logic [DATA_W-1:0] data,
                                       logic [KEY_W-1:0] rref, logic last);
        t_result r;
        r.kind       = kind;
        r.thread     = t[TID_W-1:0];
        r.callback   = cb;
        r.data       = data;
        r.return_ref = rref;
        r.last       = last;
        owed_results = {owed_results, r};
    endfunction

    // Applies one accepted beat to the shadow stacks and queues its results.
    function automatic void step_stacks(t_call_event ev);
        int   t;
        int   i;
        logic dup;
        int   top;
        t = int'(ev.tid);
        if (t < THREAD_COUNT) begin
            case (ev.op)
                OP_REGISTER: begin
                    // Only the top run of entries with an equal key is searched.
                    dup = 1'b0;
                    i   = st_fill[t];
                    while (i > 0 && !dup) begin
                        if (st_key[t][i-1] != ev.sp) break;
                        if (st_cb[t][i-1] == ev.cb) dup = 1'b1;
                        else i--;
                    end
                    if (dup) begin
                        owe_result(KIND_DUPLICATE, t, '0, '0, '0, 1'b0);
                    end else if (st_fill[t] >= STACK_DEPTH) begin
                        owe_result(KIND_FULL, t, '0, '0, '0, 1'b0);
                    end else begin
                        st_key[t][st_fill[t]]  = ev.sp;
                        st_cb[t][st_fill[t]]   = ev.cb;
                        st_data[t][st_fill[t]] = ev.data;
                        st_fill[t]++;
                        owe_result(KIND_REGISTERED, t, '0, '0, '0, 1'b0);
                    end
                end
                OP_RETURN: begin
                    // Frames skipped over fire as missed, the matching frame
                    // fires with the return reference.
                    while (st_fill[t] > 0) begin
                        top = st_fill[t] - 1;
                        if (!(st_key[t][top] < ev.sp)) break;
                        owe_result(KIND_MISSED, t, st_cb[t][top], st_data[t][top],
                                   '0, 1'b0);
                        st_fill[t]--;
                    end
                    while (st_fill[t] > 0) begin
                        top = st_fill[t] - 1;
                        if (st_key[t][top] != ev.sp) break;
                        owe_result(KIND_RETURN, t, st_cb[t][top], st_data[t][top],
                                   ev.rref, 1'b0);
                        st_fill[t]--;
                    end
                end
                OP_UNWIND: begin
                    while (st_fill[t] > 0) begin
                        top = st_fill[t] - 1;
                        if (st_key[t][top] > ev.sp) break;
                        owe_result(KIND_UNWIND, t, st_cb[t][top], st_data[t][top],
                                   '0, 1'b0);
                        st_fill[t]--;
                    end
                end
                default: ;
            endcase
        end
        owe_result(KIND_DONE, t, '0, '0, '0, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void compare_field(string name, logic [KEY_W-1:0] want,
                                          logic [KEY_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h",
                     $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Every result beat taken is matched against the oldest owed result.
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_results.size() == 0) begin
                $display("%0t: result beat with nothing owed: expected none, actual kind %0d",
                         $time, o_result_kind);
                fail_count++;
            end else begin
                want = owed_results.pop_front();
                compare_field("result_kind", KEY_W'(want.kind), KEY_W'(o_result_kind));
                compare_field("out_thread", KEY_W'(want.thread), KEY_W'(o_out_thread));
                compare_field("fired_callback", KEY_W'(want.callback),
                              KEY_W'(o_fired_callback));
                compare_field("fired_data", KEY_W'(want.data), KEY_W'(o_fired_data));
                compare_field("fired_return_ref", want.return_ref, o_fired_return_ref);
                compare_field("last", KEY_W'(want.last), KEY_W'(o_last));
            end
        end
    end

    // Result side: random stalls, a steady stretch, and long hold-offs on request.
    initial begin : result_sink
        int hold_left;
        int served;
        hold_left = 0;
        served    = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (served != hold_requests) begin
                served    = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (steady) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [KEY_W-1:0] rand_key();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[KEY_W-1:0];
    endfunction

    function automatic t_call_event ev_of(t_op op, int t, logic [KEY_W-1:0] sp,
                                          logic [CB_W-1:0] cb,
                                          logic [DATA_W-1:0] data,
                                          logic [KEY_W-1:0] rref);
        t_call_event ev;
        ev.op   = op;
        ev.tid  = t[TID_W-1:0];
        ev.sp   = sp;
        ev.cb   = cb;
        ev.data = data;
        ev.rref = rref;
        return ev;
    endfunction

    // Offers one input beat, with a random gap in front, and waits for it to
    // be taken. Valid stays up after acceptance until the next gap or pause.
    task automatic send_event(t_call_event ev);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        i_in_valid      <= 1'b1;
        i_op            <= ev.op;
        i_thread_id     <= ev.tid;
        i_stack_pointer <= ev.sp;
        i_callback_id   <= ev.cb;
        i_user_data     <= ev.data;
        i_return_ref    <= ev.rref;
        do @(posedge i_clk); while (!o_in_ready);
        step_stacks(ev);
    endtask

    // Stops offering and waits until every owed result beat has come back.
    task automatic await_all_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (owed_results.size() != 0);
    endtask

    // Random call and return traffic, aimed at keys actually on the stacks.
    task automatic run_random_events(int count);
        t_call_event ev;
        int          t;
        int          fill;
        int          sel;
        int          j;
        for (int n = 0; n < count; n++) begin
            t    = $urandom_range(THREAD_COUNT - 1);
            fill = st_fill[t];
            sel  = $urandom_range(99);
            ev   = ev_of(OP_REGISTER, t, rand_key(), CB_W'($urandom()), $urandom(),
                         rand_key());
            if (sel < 12) begin
                // Noise: any op with arbitrary fields.
                ev.op = t_op'($urandom_range(3));
            end else if (sel < 52 || fill == 0) begin
                // Register in the current frame or in a new, deeper frame.
                if ($urandom_range(99) < 70) ev.cb = CB_W'($urandom_range(7));
                if (fill > 0) begin
                    ev.sp = st_key[t][fill-1];
                    if ($urandom_range(1)) ev.sp = ev.sp - KEY_W'($urandom_range(512, 1));
                end
            end else if (sel < 82) begin
                // Return to the top frame or one or two frames further out.
                ev.op = OP_RETURN;
                j     = fill - 1 - $urandom_range((fill > 2) ? 2 : fill - 1);
                ev.sp = st_key[t][j];
                if ($urandom_range(99) < 20) ev.sp = ev.sp + KEY_W'(1);
            end else begin
                ev.op = OP_UNWIND;
                ev.sp = st_key[t][$urandom_range(fill - 1)];
            end
            send_event(ev);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corner items: empty stacks, extreme keys and handles, the unused op,
    // duplicates within and beyond the top run, partial and full pops.
    task automatic test_directed();
        send_event(ev_of(OP_RETURN, 0, KEY_MAX, '0, '0, KEY_MAX));
        send_event(ev_of(OP_UNWIND, 1, '0, '0, '0, '0));
        send_event(ev_of(OP_UNUSED, 2, KEY_MAX, '1, '1, KEY_MAX));
        send_event(ev_of(OP_REGISTER, 0, KEY_MAX, '1, '1, '0));
        send_event(ev_of(OP_REGISTER, 0, KEY_MAX, '1, '0, '0));
        send_event(ev_of(OP_REGISTER, 0, KEY_MAX, '0, '0, '0));
        send_event(ev_of(OP_REGISTER, 0, 48'h8000_0000_0000, 16'h0001, 32'hA5A5_5A5A, '0));
        send_event(ev_of(OP_REGISTER, 0, '0, '0, 32'h0000_0001, '0));
        // The unused op must leave a loaded stack alone.
        send_event(ev_of(OP_UNUSED, 0, '0, '0, '0, '0));
        send_event(ev_of(OP_RETURN, 0, 48'h8000_0000_0000, '0, '0, KEY_MAX));
        send_event(ev_of(OP_RETURN, 0, KEY_MAX, '0, '0, 48'h5555_5555_5555));
        send_event(ev_of(OP_REGISTER, 1, 48'd100, 16'd5, $urandom(), '0));
        send_event(ev_of(OP_REGISTER, 1, 48'd100, 16'd6, $urandom(), '0));
        // Duplicate found below the top entry of the run.
        send_event(ev_of(OP_REGISTER, 1, 48'd100, 16'd5, $urandom(), '0));
        send_event(ev_of(OP_REGISTER, 1, 48'd80, 16'd5, $urandom(), '0));
        // The run is broken by the lower key, so this is not a duplicate.
        send_event(ev_of(OP_REGISTER, 1, 48'd100, 16'd6, $urandom(), '0));
        send_event(ev_of(OP_UNWIND, 1, 48'd99, '0, '0, '0));
        send_event(ev_of(OP_RETURN, 1, 48'd100, '0, '0, rand_key()));
        send_event(ev_of(OP_UNWIND, 1, 48'd100, '0, '0, '0));
        send_event(ev_of(OP_REGISTER, 2, 48'h0000_FFFF_0000, 16'hAAAA, 32'h5555_AAAA, '0));
        send_event(ev_of(OP_REGISTER, 3, 48'hFFFF_0000_FFFF, 16'h5555, 32'hAAAA_5555, '0));
        send_event(ev_of(OP_RETURN, 2, 48'h0000_FFFF_0001, '0, '0, 48'hAAAA_AAAA_AAAA));
        send_event(ev_of(OP_UNWIND, 3, KEY_MAX, '0, '0, '0));
        await_all_results();
    endtask

    // Fills one stack to the top in a single frame, then checks that a
    // duplicate still wins over full, that full pushes nothing, and that one
    // return fires the whole stack.
    task automatic test_full_stack();
        int               t;
        logic [KEY_W-1:0] key;
        logic [CB_W-1:0]  base;
        t    = $urandom_range(THREAD_COUNT - 1);
        key  = rand_key();
        base = CB_W'($urandom());
        send_event(ev_of(OP_UNWIND, t, KEY_MAX, '0, '0, '0));
        for (int i = 0; i < STACK_DEPTH; i++)
            send_event(ev_of(OP_REGISTER, t, key, base + CB_W'(i), $urandom(), '0));
        send_event(ev_of(OP_REGISTER, t, key,
                         base + CB_W'($urandom_range(STACK_DEPTH - 1)), $urandom(), '0));
        send_event(ev_of(OP_REGISTER, t, key, base + CB_W'(STACK_DEPTH), $urandom(), '0));
        send_event(ev_of(OP_REGISTER, t, key - 1, CB_W'($urandom()), $urandom(), '0));
        send_event(ev_of(OP_RETURN, t, key, '0, '0, rand_key()));
        await_all_results();
    endtask

    // The result side stops for a long stretch while items keep coming, so
    // the block backs up and holds its input.
    task automatic test_backpressure();
        hold_requests++;
        run_random_events(16);
        await_all_results();
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_streaming();
        steady = 1'b1;
        run_random_events(40);
        await_all_results();
        steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_random_events(30);
        await_all_results();
        run_random_events(30);
        await_all_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_op            <= OP_REGISTER;
        i_thread_id     <= '0;
        i_stack_pointer <= '0;
        i_callback_id   <= '0;
        i_user_data     <= '0;
        i_return_ref    <= '0;
        for (int t = 0; t < THREAD_COUNT; t++) st_fill[t] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_full_stack();
        test_random_traffic();
        test_backpressure();
        test_streaming();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: stack_keyed_callback_stack_top.f
rtl/core/skcs_pkg.sv
rtl/core/skcs_ram.sv
rtl/core/skcs_cmp.sv
rtl/core/skcs_ctrl.sv
rtl/core/stack_keyed_callback_stack_top.sv
test/testbench.sv
